// File: rtl/core/pcr_pkg.sv
`timescale 1ns / 1ps

package pcr_pkg;

  localparam int PRIME_W  = 30;            // prime_value and target_term
  localparam int MOD_W    = 53;            // modulus register
  localparam int RES_W    = 52;            // residue, always below the modulus
  localparam int FACT_W   = 34;            // 10^10 fits in 34 bits
  localparam int SUM_W    = RES_W + 2;     // 2*r + bit, or r + a
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET  = 1'b1;

  localparam logic [MOD_W-1:0]   MOD_RESET    = 53'd3;
  localparam logic [MOD_W-1:0]   MOD_ONE      = 53'd1;
  localparam logic [MOD_W-1:0]   MOD_MAX      = {1'b1, 52'd0};
  localparam logic [PRIME_W-1:0] TARGET_RESET = 30'd11;
  localparam logic [RES_W-1:0]   SEED_VALUE   = 52'd2357;

  // Power of ten that makes room for p's decimal digits (at least two).
  function automatic logic [FACT_W-1:0] shift_factor(input logic [PRIME_W-1:0] p);
    logic [FACT_W-1:0] f;
    if (p < 30'd100)             f = 34'd100;
    else if (p < 30'd1000)       f = 34'd1000;
    else if (p < 30'd10000)      f = 34'd10000;
    else if (p < 30'd100000)     f = 34'd100000;
    else if (p < 30'd1000000)    f = 34'd1000000;
    else if (p < 30'd10000000)   f = 34'd10000000;
    else if (p < 30'd100000000)  f = 34'd100000000;
    else if (p < 30'd1000000000) f = 34'd1000000000;
    else                         f = 34'd10000000000;
    return f;
  endfunction

endpackage

// File: rtl/core/pcr_stream_if.sv
`timescale 1ns / 1ps

interface pcr_in_if;
  logic                            valid;
  logic                            ready;
  logic [pcr_pkg::PRIME_W-1:0]     prime_value;
  logic                            start_req;

  modport source (output valid, output prime_value, output start_req, input ready);
  modport sink   (input valid, input prime_value, input start_req, output ready);
endinterface

interface pcr_out_if;
  logic                            valid;
  logic                            ready;
  logic                            divides;
  logic [pcr_pkg::RES_W-1:0]       final_residue;

  modport source (output valid, output divides, output final_residue, input ready);
  modport sink   (input valid, input divides, input final_residue, output ready);
endinterface

// File: rtl/core/prime_concatenation_residue_unit.sv
`timescale 1ns / 1ps

// Appends each requested prime, in decimal, to the number 2357 || 11 || 13 || ...
// held modulo the configured modulus, and reports once whether the modulus
// divides the number when the prime equals target_term. A request with
// start_req set reloads the seed 2357 first; after a report, requests without
// start_req are taken and dropped. All modular arithmetic runs bit serially
// through one 54-bit add-and-compare unit: it reduces the stored residue (or
// seed) one bit at a time, multiplies by the power of ten (double and add over
// 34 multiplier bits), reduces the prime and finishes with one add. The next
// request is taken only after that final add, and a report first waits for a
// free output register. Write configuration only while no request is in flight.
module prime_concatenation_residue_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  pcr_in_if.sink                               in_chan,
  pcr_out_if.source                            out_chan,
  input  logic                                 cfg_we,
  input  logic [pcr_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [pcr_pkg::MOD_W-1:0]            cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RED,
    S_MDBL,
    S_MADD,
    S_PRED,
    S_FIN
  } state_t;

  localparam logic [5:0] RED_LAST  = 6'(pcr_pkg::RES_W - 1);
  localparam logic [5:0] MUL_LAST  = 6'(pcr_pkg::FACT_W - 1);
  localparam logic [5:0] PRED_LAST = 6'(pcr_pkg::PRIME_W - 1);

  state_t                          state_r;
  logic [pcr_pkg::MOD_W-1:0]       eff_mod_r;
  logic [pcr_pkg::PRIME_W-1:0]     target_r;
  logic [pcr_pkg::RES_W-1:0]       residue_r;
  logic                            finished_r;
  logic [pcr_pkg::RES_W-1:0]       acc_r;
  logic [pcr_pkg::RES_W-1:0]       a_r;
  logic [pcr_pkg::RES_W-1:0]       src_r;
  logic [pcr_pkg::PRIME_W-1:0]     p_r;
  logic [pcr_pkg::FACT_W-1:0]      f_r;
  logic                            hit_r;
  logic [5:0]                      cnt_r;
  logic                            out_valid_r;
  logic                            divides_r;
  logic [pcr_pkg::RES_W-1:0]       res_out_r;

  logic [pcr_pkg::SUM_W-1:0]       opx;
  logic [pcr_pkg::SUM_W-1:0]       opy;
  logic [pcr_pkg::SUM_W-1:0]       sum;
  logic [pcr_pkg::SUM_W-1:0]       red;
  logic [pcr_pkg::RES_W-1:0]       res;
  logic                            in_take;
  logic                            out_free;

  assign in_chan.ready          = (state_r == S_IDLE);
  assign in_take                = in_chan.valid && in_chan.ready;
  assign out_free               = !out_valid_r || out_chan.ready;
  assign out_chan.valid         = out_valid_r;
  assign out_chan.divides       = divides_r;
  assign out_chan.final_residue = res_out_r;

  // Configuration: saturate the modulus into 1 .. 2^52 on write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_mod_r <= pcr_pkg::MOD_RESET;
      target_r  <= pcr_pkg::TARGET_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        pcr_pkg::CFG_MODULUS: begin
          if (cfg_wdata == '0) begin
            eff_mod_r <= pcr_pkg::MOD_ONE;
          end else if (cfg_wdata > pcr_pkg::MOD_MAX) begin
            eff_mod_r <= pcr_pkg::MOD_MAX;
          end else begin
            eff_mod_r <= cfg_wdata;
          end
        end
        pcr_pkg::CFG_TARGET: begin
          target_r <= cfg_wdata[pcr_pkg::PRIME_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Shared add-and-compare: every operand pair stays below twice the modulus.
  always_comb begin
    opx = '0;
    opy = '0;
    case (state_r)
      S_RED: begin
        opx = {1'b0, acc_r, 1'b0};
        opy = {{(pcr_pkg::SUM_W-1){1'b0}}, src_r[pcr_pkg::RES_W-1]};
      end
      S_MDBL: begin
        opx = {1'b0, acc_r, 1'b0};
      end
      S_MADD: begin
        opx = {2'b00, acc_r};
        opy = f_r[pcr_pkg::FACT_W-1] ? {2'b00, a_r} : '0;
      end
      S_PRED: begin
        opx = {1'b0, a_r, 1'b0};
        opy = {{(pcr_pkg::SUM_W-1){1'b0}}, p_r[pcr_pkg::PRIME_W-1]};
      end
      S_FIN: begin
        opx = {2'b00, acc_r};
        opy = {2'b00, a_r};
      end
      default: begin
      end
    endcase
    sum = opx + opy;
    red = (sum >= {1'b0, eff_mod_r}) ? sum - {1'b0, eff_mod_r} : sum;
    res = red[pcr_pkg::RES_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      residue_r   <= '0;
      finished_r  <= 1'b1;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      if (out_valid_r && out_chan.ready && !(state_r == S_FIN && hit_r)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          // drop requests after a report unless they restart
          if (in_take && (in_chan.start_req || !finished_r)) begin
            src_r <= in_chan.start_req ? pcr_pkg::SEED_VALUE : residue_r;
            p_r   <= in_chan.prime_value;
            f_r   <= pcr_pkg::shift_factor(in_chan.prime_value);
            hit_r <= (in_chan.prime_value == target_r);
            acc_r <= '0;
            cnt_r <= '0;
            if (in_chan.start_req) begin
              finished_r <= 1'b0;
            end
            state_r <= S_RED;
          end
        end
        S_RED: begin
          src_r <= {src_r[pcr_pkg::RES_W-2:0], 1'b0};
          if (cnt_r == RED_LAST) begin
            a_r     <= res;
            acc_r   <= '0;
            cnt_r   <= '0;
            state_r <= S_MDBL;
          end else begin
            acc_r <= res;
            cnt_r <= cnt_r + 6'd1;
          end
        end
        S_MDBL: begin
          acc_r   <= res;
          state_r <= S_MADD;
        end
        S_MADD: begin
          acc_r <= res;
          f_r   <= {f_r[pcr_pkg::FACT_W-2:0], 1'b0};
          if (cnt_r == MUL_LAST) begin
            a_r     <= '0;
            cnt_r   <= '0;
            state_r <= S_PRED;
          end else begin
            cnt_r   <= cnt_r + 6'd1;
            state_r <= S_MDBL;
          end
        end
        S_PRED: begin
          a_r <= res;
          p_r <= {p_r[pcr_pkg::PRIME_W-2:0], 1'b0};
          if (cnt_r == PRED_LAST) begin
            cnt_r   <= '0;
            state_r <= S_FIN;
          end else begin
            cnt_r <= cnt_r + 6'd1;
          end
        end
        S_FIN: begin
          // hold a report until the output register is free
          if (!hit_r || out_free) begin
            residue_r <= res;
            if (hit_r) begin
              out_valid_r <= 1'b1;
              divides_r   <= (res == '0);
              res_out_r   <= res;
              finished_r  <= 1'b1;
            end
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result raised outside the final step");

  a_finished_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> finished_r)
    else $error("result given without marking the run finished");

  a_divides_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (divides_r == (res_out_r == '0)))
    else $error("divides flag disagrees with the residue");

  a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |=> ($past(in_chan.ready) == 1'b0))
    else $error("request taken while busy");
`endif

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int STALL_LIMIT   = 20000;
  localparam int SETTLE_CYCLES = 200;   // longer than one prime takes
  localparam int HOLD_CYCLES   = 2000;
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    logic                      divides;
    logic [pcr_pkg::RES_W-1:0] final_residue;
  } verdict_t;

  // Tracks the concatenation residue and holds the verdicts still owed.
  class concat_residue_checker;
    logic [pcr_pkg::MOD_W-1:0]   modulus;
    logic [pcr_pkg::PRIME_W-1:0] target;
    logic [pcr_pkg::RES_W-1:0]   residue;
    bit                          finished;
    verdict_t                    owed_verdicts[$];
    int                          mismatches;
    int                          verdicts_checked;
    int                          verdicts_divisible;
    int                          requests_seen;

    function new();
      modulus  = pcr_pkg::MOD_RESET;
      target   = pcr_pkg::TARGET_RESET;
      residue  = '0;
      finished = 1'b1;
    endfunction

    static function logic [63:0] decimal_shift(input logic [pcr_pkg::PRIME_W-1:0] p);
      logic [63:0] f;
      f = 64'd100;
      while (f <= 64'(p) && f < 64'd10000000000) f = f * 64'd10;
      return f;
    endfunction

    function void write_register(input logic [pcr_pkg::CFG_IDX_W-1:0] idx,
                                 input logic [pcr_pkg::MOD_W-1:0] value);
      if (idx == pcr_pkg::CFG_MODULUS) modulus = value;
      else if (idx == pcr_pkg::CFG_TARGET) target = value[pcr_pkg::PRIME_W-1:0];
    endfunction

    function void note_request(input logic [pcr_pkg::PRIME_W-1:0] p, input logic start);
      logic [127:0] m;
      logic [127:0] acc;
      verdict_t     v;
      requests_seen++;
      m = 128'(modulus);
      if (m == 0) m = 128'd1;
      if (m > 128'(pcr_pkg::MOD_MAX)) m = 128'(pcr_pkg::MOD_MAX);
      if (start) begin
        residue  = pcr_pkg::RES_W'(128'(pcr_pkg::SEED_VALUE) % m);
        finished = 1'b0;
      end
      if (finished) return;
      // reduce by the current modulus first: it may have changed since the last prime
      acc = (128'(residue) % m) * 128'(decimal_shift(p));
      acc = acc % m;
      acc = (acc + 128'(p) % m) % m;
      residue = acc[pcr_pkg::RES_W-1:0];
      if (p == target) begin
        finished        = 1'b1;
        v.divides       = (residue == '0);
        v.final_residue = residue;
        owed_verdicts.push_back(v);
      end
    endfunction

    function void note_mismatch(input string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("MISMATCH %s", msg);
    endfunction

    function void check_verdict(input logic divides,
                                input logic [pcr_pkg::RES_W-1:0] final_residue);
      verdict_t v;
      if (owed_verdicts.size() == 0) begin
        note_mismatch($sformatf("unexpected result: divides %0d, residue %0d",
                                divides, final_residue));
        return;
      end
      v = owed_verdicts.pop_front();
      verdicts_checked++;
      if (v.divides) verdicts_divisible++;
      if (divides !== v.divides)
        note_mismatch($sformatf("divides: expected %0d, got %0d", v.divides, divides));
      if (final_residue !== v.final_residue)
        note_mismatch($sformatf("final_residue: expected %0d, got %0d",
                                v.final_residue, final_residue));
    endfunction

    function int pending();
      return owed_verdicts.size();
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          cfg_we;
  logic [pcr_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [pcr_pkg::MOD_W-1:0]     cfg_wdata;

  pcr_in_if  in_bus();
  pcr_out_if out_bus();

  concat_residue_checker chk;
  bit  calm;
  int  hold_requests;
  int  holds_done;
  int  stall_cycles;
  int  settings_applied;

  prime_concatenation_residue_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_bus),
    .out_chan  (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  // Handshake monitors and the watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready)
        chk.note_request(in_bus.prime_value, in_bus.start_req);
      if (out_bus.valid && out_bus.ready)
        chk.check_verdict(out_bus.divides, out_bus.final_residue);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Watchdog: no handshake for %0d cycles, %0d verdicts owed",
                 stall_cycles, chk.pending());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Result side: random back-pressure, or one long hold-off on request
  initial begin
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_done != hold_requests) begin
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end else begin
        out_bus.ready <= calm || ($urandom_range(99, 0) >= 37);
      end
    end
  end

  function automatic logic [pcr_pkg::PRIME_W-1:0] rand_term();
    int unsigned k;
    int unsigned lo;
    k = $urandom_range(9, 1);
    if (k == 1) return pcr_pkg::PRIME_W'($urandom_range(99, 0));
    if (k == 9) return pcr_pkg::PRIME_W'($urandom_range(32'h3FFF_FFFF, 1000000000));
    lo = 1;
    repeat (k) lo = lo * 10;
    return pcr_pkg::PRIME_W'($urandom_range(lo * 10 - 1, lo));
  endfunction

  function automatic logic [pcr_pkg::MOD_W-1:0] pick_modulus();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(9, 0))
      0: return pcr_pkg::MOD_W'($urandom_range(999, 3) | 1);
      1: return pcr_pkg::MOD_W'(r[31:0] & ~32'd1);
      2, 3: return pcr_pkg::MOD_W'(r[31:0] | 32'd1);
      4, 5: return pcr_pkg::MOD_W'(r[51:0] | 52'd1);
      6: return r[pcr_pkg::MOD_W-1:0];
      7: begin
        case ($urandom_range(6, 0))
          0: return '0;
          1: return pcr_pkg::MOD_W'(1);
          2: return pcr_pkg::MOD_W'(2);
          3: return pcr_pkg::MOD_MAX;
          4: return pcr_pkg::MOD_MAX - 1;
          5: return pcr_pkg::MOD_MAX + 1;
          default: return '1;
        endcase
      end
      default: return pcr_pkg::MOD_W'(r[39:0] | 40'd1);
    endcase
  endfunction

  task automatic offer_term(input logic [pcr_pkg::PRIME_W-1:0] p, input logic start);
    while (!calm && $urandom_range(99, 0) < 37) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid       <= 1'b1;
    in_bus.prime_value <= p;
    in_bus.start_req   <= start;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
  endtask

  // Drop valid, wait for every owed verdict, then let the block go idle.
  task automatic settle();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (chk.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_registers(input bit set_mod,
                                   input logic [pcr_pkg::MOD_W-1:0] mod_value,
                                   input bit set_target,
                                   input logic [pcr_pkg::PRIME_W-1:0] target_value);
    logic [pcr_pkg::MOD_W-1:0] word;
    word = pcr_pkg::MOD_W'({$urandom, $urandom});
    word[pcr_pkg::PRIME_W-1:0] = target_value;   // upper bits are don't-care for the target
    if (set_mod) begin
      cfg_we    <= 1'b1;
      cfg_index <= pcr_pkg::CFG_MODULUS;
      cfg_wdata <= mod_value;
      @(posedge clk);
      chk.write_register(pcr_pkg::CFG_MODULUS, mod_value);
    end
    if (set_target) begin
      cfg_we    <= 1'b1;
      cfg_index <= pcr_pkg::CFG_TARGET;
      cfg_wdata <= word;
      @(posedge clk);
      chk.write_register(pcr_pkg::CFG_TARGET, word);
    end
    cfg_we <= 1'b0;
    settings_applied++;
  endtask

  initial begin
    int                          random_terms;
    int                          phase;
    int                          len;
    int                          n_terms;
    bit                          miss;
    logic [pcr_pkg::PRIME_W-1:0] goal;
    logic [pcr_pkg::PRIME_W-1:0] p;
    logic [pcr_pkg::PRIME_W-1:0] chain [0:2];
    logic [127:0]                whole;
    logic [127:0]                grown;

    chk = new();
    rst_n              <= 1'b0;
    in_bus.valid       <= 1'b0;
    in_bus.prime_value <= '0;
    in_bus.start_req   <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= pcr_pkg::CFG_MODULUS;
    cfg_wdata          <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: finished after reset, so plain requests are dropped
    offer_term(30'd11, 1'b0);
    offer_term(30'd11, 1'b1);
    offer_term(30'd13, 1'b0);
    settle();
    // modulus equal to 2357||11||13 divides it
    program_registers(1'b1, 53'd23571113, 1'b1, 30'd13);
    offer_term(30'd11, 1'b1);
    offer_term(30'd13, 1'b0);
    settle();
    program_registers(1'b1, '0, 1'b1, '0);
    offer_term('0, 1'b1);
    settle();
    program_registers(1'b1, 53'd1, 1'b1, '1);
    offer_term(30'd5, 1'b1);
    offer_term('1, 1'b0);
    settle();
    // modulus saturates; cross the 2/3 and 9/10 digit-count boundaries
    program_registers(1'b1, '1, 1'b1, 30'd999999999);
    offer_term(30'd99, 1'b1);
    offer_term(30'd100, 1'b0);
    offer_term(30'd999, 1'b0);
    offer_term(30'd1000000000, 1'b0);
    offer_term(30'd999999999, 1'b0);
    settle();
    // change the modulus twice in the middle of one concatenation
    program_registers(1'b1, pcr_pkg::MOD_MAX - 1, 1'b1, 30'd12345);
    offer_term(30'd97, 1'b1);
    offer_term(30'd101, 1'b0);
    settle();
    program_registers(1'b1, 53'd1000000006, 1'b0, '0);
    offer_term(30'd103, 1'b0);
    settle();
    program_registers(1'b1, pcr_pkg::MOD_MAX, 1'b0, '0);
    offer_term(30'd12345, 1'b0);
    settle();
    // move the target while a concatenation is open
    program_registers(1'b0, '0, 1'b1, 30'd7);
    offer_term(30'd10, 1'b1);
    offer_term(30'd9, 1'b0);
    settle();
    program_registers(1'b0, '0, 1'b1, 30'd9);
    offer_term(30'd9, 1'b0);

    // Random concatenations, one register setting each
    random_terms = 0;
    phase        = 0;
    while (random_terms < 630) begin
      calm = (phase >= 12 && phase < 22);
      settle();
      if (phase == 35) begin
        // back up the block behind a stalled result port
        goal = rand_term();
        program_registers(1'b1, pick_modulus(), 1'b1, goal);
        hold_requests++;
        for (int i = 0; i < 6; i++) begin
          offer_term(rand_term(), 1'b1);
          offer_term(goal, 1'b0);
          random_terms += 2;
        end
      end else if ($urandom_range(99, 0) < 12) begin
        // short chain whose exact value is the modulus
        whole   = 128'(pcr_pkg::SEED_VALUE);
        n_terms = 0;
        for (int i = 0; i < 3; i++) begin
          p     = pcr_pkg::PRIME_W'($urandom_range(9999, 10));
          grown = whole * 128'(concat_residue_checker::decimal_shift(p)) + 128'(p);
          if (grown < 128'(pcr_pkg::MOD_MAX)) begin
            whole          = grown;
            chain[n_terms] = p;
            n_terms++;
          end
        end
        if (n_terms == 0) begin
          chain[0] = 30'd11;
          whole    = 128'd235711;
          n_terms  = 1;
        end
        program_registers(1'b1, whole[pcr_pkg::MOD_W-1:0], 1'b1, chain[n_terms-1]);
        for (int i = 0; i < n_terms; i++) begin
          offer_term(chain[i], i == 0);
          random_terms++;
        end
      end else begin
        len  = $urandom_range(12, 1);
        goal = rand_term();
        miss = ($urandom_range(99, 0) < 8);
        program_registers($urandom_range(99, 0) < 75, pick_modulus(), 1'b1, goal);
        for (int i = 0; i < len; i++) begin
          p = (i == len - 1 && !miss) ? goal : rand_term();
          offer_term(p, i == 0 || $urandom_range(99, 0) < 5);
          random_terms++;
        end
        // trailing requests without a restart
        if ($urandom_range(99, 0) < 20)
          repeat ($urandom_range(3, 1)) offer_term(rand_term(), 1'b0);
      end
      phase++;
    end
    calm = 1'b0;

    settle();
    $display("Ran %0d requests in %0d register settings; %0d verdicts checked, %0d divisible.",
             chk.requests_seen, settings_applied, chk.verdicts_checked,
             chk.verdicts_divisible);
    $display("Covered saturated, zero and even moduli, mid-chain changes, dropped requests",
             " and a long result stall.");
    if (chk.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", chk.mismatches);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
